>>> src/mi4_pkg.sv
// Shared types and constants for the 4x4 matrix inverse block.
// Used by mi4_front, mi4_queue, mi4_back and matrix_inverse_4x4.
package mi4_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int N_ELEM      = 16;
  localparam int IDX_W       = $clog2(N_ELEM);
  localparam int QDEPTH      = 2;

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;
  typedef elem_t [N_ELEM-1:0] mat_t;

  typedef struct packed {
    logic [IDX_W-1:0]              element_index;
    logic signed [VALUE_WIDTH-1:0] element_value;
    logic                          last_element;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]              result_index;
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic                          singular;
    logic                          saturated;
    logic                          last_result;
  } out_item_t;

  // one matrix moving between front, queue and back
  typedef struct packed {
    logic valid;
    mat_t mat;
  } mat_xfer_t;

endpackage

>>> src/mi4_front.sv
// Front end: takes element transfers, keeps the element store and hands a
// full matrix to the queue when the last element arrives. Uses mi4_pkg.
module mi4_front (
  input  logic                clk,
  input  logic                element_valid,
  output logic                element_ready,
  input  mi4_pkg::in_item_t   element,
  input  logic                q_full,
  output mi4_pkg::mat_xfer_t  push
);
  import mi4_pkg::*;

  mat_t store;
  logic accept;

  assign element_ready = !q_full;
  assign accept = element_valid && element_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      store[element.element_index] <= element.element_value;
    end
  end

  always_comb begin
    push.mat = store;
    push.mat[element.element_index] = element.element_value;
    push.valid = accept && element.last_element;
  end

endmodule

>>> src/mi4_queue.sv
// Short matrix queue between front and back.
// Uses mi4_pkg.
module mi4_queue (
  input  logic                clk,
  input  logic                rst,
  input  mi4_pkg::mat_xfer_t  push,
  output logic                full,
  output mi4_pkg::mat_xfer_t  head,
  input  logic                pop
);
  import mi4_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  mat_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.mat = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.mat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(pop);
    end
  end

endmodule

>>> src/mi4_back.sv
// Back end: cofactors and determinant on one shared multiplier, restoring
// division and the result output register. Uses mi4_pkg.
module mi4_back (
  input  logic                clk,
  input  logic                rst,
  input  mi4_pkg::mat_xfer_t  head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output mi4_pkg::out_item_t  result
);
  import mi4_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int COF_W  = 3 * VW + 1;
  localparam int ACC_W  = 4 * VW + 8;
  localparam int EXT_W  = 4 * VW;
  localparam int MUL_W  = VW + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = ACC_W + VW;
  localparam int BIT_W  = $clog2(VW);
  localparam int SH_W   = $clog2(EXT_W);

  localparam logic [VW:0] SIGN_Q = (VW + 1)'(1) << (VW - 1);
  localparam logic [VW:0] MAX_Q  = SIGN_Q - 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_COF    = 9'b000000010,
    ST_CSTORE = 9'b000000100,
    ST_DET    = 9'b000001000,
    ST_DINIT  = 9'b000010000,
    ST_SATCHK = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_ROUND  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  // index of the i-th row/column that remains after dropping one
  function automatic logic [1:0] skip_map(input logic [1:0] skip, input logic [1:0] i);
    skip_map = (i < skip) ? i : i + 2'd1;
  endfunction

  // 3x3 permutations: {col of row 0, col of row 1, col of row 2}
  function automatic logic [5:0] perm_of(input logic [2:0] t);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd0, 2'd1, 2'd2};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd2, 2'd1, 2'd0};
      default: p = '0;
    endcase
    perm_of = p;
  endfunction

  state_t                    state;
  logic [IDX_W-1:0]          cof_idx;
  logic [2:0]                term;
  logic [1:0]                ph;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VW-1:0]      phi;
  logic signed [ACC_W-1:0]   acc;
  logic signed [COF_W-1:0]   cof [N_ELEM];
  logic [ACC_W-1:0]          dabs;
  logic [NUM_W-1:0]          rem;
  logic [NUM_W-1:0]          dsh;
  logic [VW-1:0]             qbits;
  logic [BIT_W-1:0]          bitc;
  logic                      big;
  logic                      qneg;
  logic                      sing;
  logic [VW-1:0]             res_val;
  logic                      res_sat;

  logic [1:0]                rr, cc, row0, row1, row2;
  logic [5:0]                perm;
  logic [IDX_W-1:0]          addr_a, addr_b, cof_addr;
  elem_t                     ea, eb;
  logic signed [COF_W-1:0]   cof_rd;
  logic signed [EXT_W-1:0]   cof_ext;
  logic [VW-1:0]             chunk;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   addend, acc_sum;
  logic [SH_W-1:0]           shamt;
  logic                      neg;
  logic [ACC_W-1:0]          acc_abs;
  logic [COF_W-1:0]          cof_abs;
  logic                      ge;
  logic [VW:0]               q1;
  logic                      sat_c;
  logic                      emit;

  always_comb begin
    rr   = cof_idx[3:2];
    cc   = cof_idx[1:0];
    perm = perm_of(term);
    row0 = skip_map(cc, 2'd0);
    row1 = skip_map(cc, 2'd1);
    row2 = skip_map(cc, 2'd2);
    if (state == ST_DET) begin
      addr_a = {2'b00, cc};
    end else if (ph == 2'd0) begin
      addr_a = {row1, skip_map(rr, perm[3:2])};
    end else begin
      addr_a = {row0, skip_map(rr, perm[5:4])};
    end
    addr_b   = {row2, skip_map(rr, perm[1:0])};
    ea       = head.mat[addr_a];
    eb       = head.mat[addr_b];
    cof_addr = (state == ST_DET) ? {cc, 2'b00} : cof_idx;
    cof_rd   = cof[cof_addr];
    cof_ext  = EXT_W'(cof_rd);
    chunk    = cof_ext[term[2:1]*VW +: VW];
    mul_a    = MUL_W'(ea);
    if (state == ST_DET) begin
      mul_b = (term[2:1] == 2'd3) ? MUL_W'(signed'(chunk)) : MUL_W'(chunk);
    end else if (ph == 2'd0) begin
      mul_b = MUL_W'(eb);
    end else if (ph == 2'd1) begin
      mul_b = MUL_W'(prod[VW-1:0]);
    end else begin
      mul_b = MUL_W'(phi);
    end
    mul_p = mul_a * mul_b;
    if (state == ST_DET) begin
      shamt = SH_W'(VW * term[2:1]);
      neg   = 1'b0;
    end else begin
      shamt = (ph == 2'd3) ? SH_W'(VW) : '0;
      neg   = (term > 3'd2) ^ rr[0] ^ cc[0];
    end
    addend  = ACC_W'(prod) <<< shamt;
    acc_sum = neg ? acc - addend : acc + addend;
    acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    cof_abs = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : COF_W'(cof_rd);
    ge      = (rem >= dsh);
    q1      = big ? SIGN_Q + 1'b1
                  : {1'b0, qbits} + (VW + 1)'(({rem[NUM_W-2:0], 1'b0}) >= NUM_W'(dabs));
    sat_c   = qneg ? (q1 > SIGN_Q) : (q1 > MAX_Q);
    emit    = (state == ST_OUT) && (!result_valid || result_ready);
    pop     = emit && (cof_idx == IDX_W'(N_ELEM - 1));
  end

  always_ff @(posedge clk) begin
    if (state == ST_CSTORE) begin
      cof[cof_idx] <= COF_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cof_idx      <= '0;
      term         <= '0;
      ph           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            acc     <= '0;
            cof_idx <= '0;
            term    <= '0;
            ph      <= '0;
            state   <= ST_COF;
          end
        end
        ST_COF: begin
          ph <= ph + 2'd1;
          unique case (ph)
            2'd0: prod <= mul_p;
            2'd1: begin
              phi  <= prod[2*VW-1:VW];
              prod <= mul_p;
            end
            2'd2: begin
              acc  <= acc_sum;
              prod <= mul_p;
            end
            default: begin
              acc <= acc_sum;
              if (term == 3'd5) begin
                term  <= '0;
                state <= ST_CSTORE;
              end else begin
                term <= term + 3'd1;
              end
            end
          endcase
        end
        ST_CSTORE: begin
          acc     <= '0;
          cof_idx <= cof_idx + 1'b1;
          term    <= '0;
          ph      <= '0;
          state   <= (cof_idx == IDX_W'(N_ELEM - 1)) ? ST_DET : ST_COF;
        end
        ST_DET: begin
          term <= term + 3'd1;
          if (!term[0]) begin
            prod <= mul_p;
          end else begin
            acc <= acc_sum;
            if (term == 3'd7) begin
              if (cc == 2'd3) begin
                cof_idx <= '0;
                state   <= ST_DINIT;
              end else begin
                cof_idx <= cof_idx + 1'b1;
              end
            end
          end
        end
        ST_DINIT: begin
          sing    <= (acc == '0);
          dabs    <= acc_abs;
          rem     <= NUM_W'(cof_abs) << (2 * FRAC_BITS);
          dsh     <= NUM_W'(acc_abs) << VW;
          qneg    <= cof_rd[COF_W-1] ^ acc[ACC_W-1];
          qbits   <= '0;
          res_val <= '0;
          res_sat <= 1'b0;
          state   <= (acc == '0) ? ST_OUT : ST_SATCHK;
        end
        ST_SATCHK: begin
          big   <= ge;
          dsh   <= dsh >> 1;
          bitc  <= BIT_W'(VW - 1);
          state <= ge ? ST_ROUND : ST_DIV;
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          qbits <= {qbits[VW-2:0], ge};
          dsh   <= dsh >> 1;
          bitc  <= bitc - 1'b1;
          if (bitc == '0) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          res_sat <= sat_c;
          if (qneg) begin
            res_val <= sat_c ? SIGN_Q[VW-1:0] : VW'(-q1);
          end else begin
            res_val <= sat_c ? MAX_Q[VW-1:0] : q1[VW-1:0];
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (emit) begin
            if (cof_idx == IDX_W'(N_ELEM - 1)) begin
              state <= ST_IDLE;
            end else begin
              cof_idx <= cof_idx + 1'b1;
              big     <= 1'b0;
              state   <= ST_DINIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.result_index <= cof_idx;
      result.result_value <= res_val;
      result.singular     <= sing;
      result.saturated    <= res_sat;
      result.last_result  <= (cof_idx == IDX_W'(N_ELEM - 1));
    end
  end

endmodule

>>> src/matrix_inverse_4x4.sv
// 4x4 matrix inverse by the adjugate, Q16.16, top level.
// Instantiates mi4_front, mi4_queue and mi4_back; uses mi4_pkg.
//
// Usage:
//   element channel: one transfer per matrix element (row*4+column index,
//   Q16.16 value). The transfer marked last_element stores its element and
//   starts an inversion of the stored matrix. Elements load one per cycle while the queue is not full.
//   result channel: sixteen transfers per inversion in row-major order,
//   last_result on the sixteenth. A zero determinant gives zeros with
//   singular set; out-of-range values clip and set saturated.
// Schedule:
//   the sixteen cofactors and then the determinant are computed on the single
//   shared 33x33 multiplier; each result then goes through the bit-serial
//   divider, which is skipped when the quotient is out of range; a singular
//   matrix skips the division steps altogether.
//   Up to two matrices wait in the queue, so loading overlaps computation.
// Reset: rst clears the queue and the sequencer; stored elements are
//   undefined until written. A stalled result receiver holds the back end;
//   the front keeps taking elements until the queue is full.
module matrix_inverse_4x4 (
  input  logic                clk,
  input  logic                rst,
  input  logic                element_valid,
  output logic                element_ready,
  input  mi4_pkg::in_item_t   element,
  output logic                result_valid,
  input  logic                result_ready,
  output mi4_pkg::out_item_t  result
);
  import mi4_pkg::*;

  mat_xfer_t push;
  mat_xfer_t head;
  logic      q_full;
  logic      pop;

  mi4_front u_front (
    .clk           (clk),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .element       (element),
    .q_full        (q_full),
    .push          (push)
  );

  mi4_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  mi4_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> test/matrix_inverse_4x4_test.sv
// Testbench for matrix_inverse_4x4: loads 4x4 Q16.16 matrices and checks every
// inverse element against an exact adjugate/determinant predictor with rounding
// and saturation. Depends on mi4_pkg and the matrix_inverse_4x4 RTL.
module matrix_inverse_4x4_test;
  import mi4_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef enum int {EXP_PREDICT, EXP_IDENTITY, EXP_SINGULAR} exp_kind_t;
  typedef enum int {VAL_SMALL, VAL_FULL, VAL_TINY, VAL_SINGULAR} val_style_t;
  typedef struct {
    in_item_t  item;
    exp_kind_t kind;
  } stim_row_t;

  localparam logic signed [VALUE_WIDTH-1:0] ONE = 1 <<< FRAC_BITS;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = 32'sh80000000;

  logic       clk = 0;
  logic       rst = 1;
  logic       element_valid = 0;
  logic       element_ready;
  in_item_t   element = '0;
  logic       result_valid;
  logic       result_ready = 0;
  out_item_t  result;

  elem_t      stored [N_ELEM];
  out_item_t  inverse_q [$];
  exp_kind_t  cur_kind = EXP_PREDICT;
  int         errors = 0;
  int         items_sent = 0;
  int         cycle = 0;
  bit         tx_quiet = 0;

  matrix_inverse_4x4 dut (
    .clk(clk), .rst(rst),
    .element_valid(element_valid), .element_ready(element_ready), .element(element),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic wide_t cell_at(int r, int c);
    wide_t w;
    w = stored[r * 4 + c];
    return w;
  endfunction

  function automatic wide_t minor3(int skip_r, int skip_c);
    int rs[3], cs[3];
    int n, m, i;
    wide_t e[3][3];
    n = 0;
    m = 0;
    for (i = 0; i < 4; i++) begin
      if (i != skip_r) rs[n++] = i;
      if (i != skip_c) cs[m++] = i;
    end
    for (i = 0; i < 9; i++) e[i / 3][i % 3] = cell_at(rs[i / 3], cs[i % 3]);
    return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
         - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
         + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
  endfunction

  function automatic out_item_t divide_round_sat(wide_t num, wide_t den);
    logic [255:0] n, d, q, rem;
    logic [63:0]  qv;
    bit           neg;
    out_item_t    o;
    o = '0;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (n >= (d << VALUE_WIDTH)) begin
      qv = (64'd1 << (VALUE_WIDTH - 1)) + 1;
    end else begin
      q = n / d;
      rem = n - q * d;
      qv = q[63:0];
      if ((rem << 1) >= d) qv++;
    end
    if (!neg) begin
      if (qv > 64'h7fffffff) begin
        o.saturated = 1;
        qv = 64'h7fffffff;
      end
      o.result_value = qv[31:0];
    end else begin
      if (qv > 64'h80000000) begin
        o.saturated = 1;
        qv = 64'h80000000;
      end
      o.result_value = -qv[31:0];
    end
    return o;
  endfunction

  task automatic predict_inverse(exp_kind_t kind);
    wide_t adj[16];
    wide_t det;
    out_item_t o;
    int r, c, k;
    det = 0;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) begin
        adj[r * 4 + c] = minor3(c, r);
        if ((r + c) % 2) adj[r * 4 + c] = -adj[r * 4 + c];
      end
    for (c = 0; c < 4; c++) det += cell_at(0, c) * adj[c * 4];
    for (k = 0; k < 16; k++) begin
      o = '0;
      if (kind == EXP_IDENTITY) begin
        o.result_value = (k % 5 == 0) ? ONE : '0;
      end else if (kind == EXP_SINGULAR || det == 0) begin
        o.singular = 1;
      end else begin
        o = divide_round_sat(adj[k] <<< (2 * FRAC_BITS), det);
      end
      o.result_index = IDX_W'(k);
      o.last_result = (k == 15);
      inverse_q.push_back(o);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
  endtask

  // element transfers update the store; result transfers are checked
  always @(posedge clk) begin
    out_item_t w;
    cycle <= cycle + 1;
    if (!rst && element_valid && element_ready) begin
      stored[element.element_index] = element.element_value;
      if (element.last_element) predict_inverse(cur_kind);
    end
    if (!rst && result_valid && result_ready) begin
      if (inverse_q.size() == 0) begin
        report("unexpected result, index", 32'(result.result_index), 32'd0);
      end else begin
        w = inverse_q.pop_front();
        if (result.result_index !== w.result_index)
          report("result_index", 32'(result.result_index), 32'(w.result_index));
        if (result.result_value !== w.result_value)
          report("result_value", result.result_value, w.result_value);
        if (result.singular !== w.singular)
          report("singular", 32'(result.singular), 32'(w.singular));
        if (result.saturated !== w.saturated)
          report("saturated", 32'(result.saturated), 32'(w.saturated));
        if (result.last_result !== w.last_result)
          report("last_result", 32'(result.last_result), 32'(w.last_result));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 6000 && cycle < 16000) result_ready <= 1;
    else result_ready <= ($urandom_range(0, 99) >= 11);
  end

  task automatic send(logic [3:0] idx, logic [31:0] val, logic last);
    if (!tx_quiet && $urandom_range(0, 99) < 11) begin
      element_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    element <= '{element_index: idx, element_value: val, last_element: last};
    element_valid <= 1;
    do @(posedge clk); while (!element_ready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value(val_style_t style);
    case (style)
      VAL_SMALL: return $urandom_range(0, 16 << FRAC_BITS) - (8 << FRAC_BITS);
      VAL_TINY:  return $urandom_range(0, 511) - 256;
      default:   return $urandom;
    endcase
  endfunction

  task automatic load_matrix(bit full);
    int order[16];
    int i, j, t, n;
    val_style_t style;
    style = val_style_t'($urandom_range(0, 3));
    if (full) begin
      for (i = 0; i < 16; i++) order[i] = i;
      for (i = 15; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (i = 0; i < 16; i++) begin
        if ($urandom_range(0, 9) == 0) send(4'($urandom_range(0, 15)), pick_value(style), 0);
        send(4'(order[i]), pick_value(style), i == 15 && style != VAL_SINGULAR);
      end
    end else begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++)
        send(4'($urandom_range(0, 15)), pick_value(style),
             i == n - 1 && style != VAL_SINGULAR);
    end
    // singular: copy row 1 into row 3
    if (style == VAL_SINGULAR)
      for (i = 0; i < 4; i++) send(4'(12 + i), stored[4 + i], i == 3);
  endtask

  initial begin
    stim_row_t rows [$];
    int i;
    for (i = 0; i < 16; i++)
      rows.push_back('{'{4'(i), (i % 5 == 0) ? ONE : '0, i == 15}, EXP_IDENTITY});
    for (i = 0; i < 4; i++) rows.push_back('{'{4'(i), '0, i == 3}, EXP_SINGULAR});
    rows.push_back('{'{4'd0, VMAX, 0}, EXP_PREDICT});
    for (i = 1; i < 4; i++) rows.push_back('{'{4'(i), '0, 0}, EXP_PREDICT});
    rows.push_back('{'{4'd5, VMIN, 0}, EXP_PREDICT});
    rows.push_back('{'{4'd10, 32'sd1, 1}, EXP_PREDICT});

    repeat (7) @(posedge clk);
    rst <= 0;
    foreach (rows[k]) begin
      cur_kind <= rows[k].kind;
      send(rows[k].item.element_index, rows[k].item.element_value,
           rows[k].item.last_element);
    end
    cur_kind <= EXP_PREDICT;

    while (items_sent < 450) begin
      tx_quiet = (items_sent > 200 && items_sent < 300);
      i = $urandom_range(0, 99);
      if (i < 15) send(4'($urandom_range(0, 15)), $urandom, 0);
      else load_matrix(i < 50);
    end
    element_valid <= 0;

    while (inverse_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
